/* rtl/dtm_pkg.sv */
// ----------------------------------------------------------------------------
// dtm_pkg
// shared widths, sizes and request codes of the deadline timer multiplexer
// ----------------------------------------------------------------------------
package dtm_pkg;

    // number of virtual timer slots
    localparam int NUM_SLOTS = 16;

    // index width of the slot store, at least one bit
    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // field widths of a request and a result
    localparam int REQ_W       = 2;
    localparam int SLOT_FIELD_W = 4;
    localparam int TIME_W      = 63;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ACTIVATE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DEACTIVATE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK       = 2'd2;

endpackage

/* rtl/deadline_timer_multiplexer.sv */
// ----------------------------------------------------------------------------
// deadline_timer_multiplexer
// shares one host timer among a fixed set of virtual timer slots
// ----------------------------------------------------------------------------
// Each scan walks the slot store one slot per cycle through a single
// 63-bit subtractor, which serves every compare and the delay computation.
// Activate runs write, earliest-deadline scan, delay and summary. Tick runs
// an expiry scan that emits one fired request per expired slot, then the
// earliest-deadline scan. Deactivate of the earliest pending slot runs a
// check scan plus a rescan; any other pending deactivate runs one scan,
// and a deactivate of a slot that is not pending goes straight to the
// summary. The expiry scan holds on an expired slot while the result waits.
// A new request is taken once the summary result is registered,
// even while it still waits to be taken.
// ----------------------------------------------------------------------------
module deadline_timer_multiplexer
    import dtm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [135:0] i_s_tdata,  // slot[3:0], deadline[66:4], now[129:67], zero pad
    input  logic [1:0]   i_s_tuser,  // req_type[1:0]
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [71:0]  o_m_tdata,  // fired_slot[3:0], stop_host[4], set_host[5],
                                     // delay[68:6], zero pad
    output logic         o_m_tuser,  // fired
    output logic         o_m_tlast   // last
);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_FIRE   = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;

    localparam int EXT_W = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

    // request fields
    logic [REQ_W-1:0]        w_req;
    logic [SLOT_FIELD_W-1:0] w_slot;
    logic [TIME_W-1:0]       w_deadline;
    logic [TIME_W-1:0]       w_now;
    logic [EXT_W-1:0]        w_slot_ext;
    logic [SLOT_W-1:0]       w_slot_idx;
    logic                    w_slot_ok;

    assign w_req      = i_s_tuser;
    assign w_slot     = i_s_tdata[3:0];
    assign w_deadline = i_s_tdata[66:4];
    assign w_now      = i_s_tdata[129:67];
    assign w_slot_ext = EXT_W'(w_slot);
    assign w_slot_idx = w_slot_ext[SLOT_W-1:0];
    assign w_slot_ok  = (7'(w_slot) < 7'(NUM_SLOTS));

    // slot store
    logic [TIME_W-1:0]    r_dl [NUM_SLOTS];
    logic [TIME_W-1:0]    r_dl_rd;
    logic [NUM_SLOTS-1:0] r_pend, n_pend;

    // sequencer registers
    logic [2:0]        r_state, n_state;
    logic [SLOT_W-1:0] r_idx, n_idx;
    logic              r_rescan, n_rescan;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [TIME_W-1:0] r_now, n_now;
    logic [TIME_W-1:0] r_best, n_best;
    logic [SLOT_W-1:0] r_best_idx, n_best_idx;
    logic              r_best_vld, n_best_vld;
    logic              r_stop, n_stop;
    logic              r_set, n_set;
    logic [TIME_W-1:0] r_delay, n_delay;

    // result register
    logic                    r_ov, n_ov;
    logic                    r_o_fired, n_o_fired;
    logic [SLOT_FIELD_W-1:0] r_o_fslot, n_o_fslot;
    logic                    r_o_stop, n_o_stop;
    logic                    r_o_set, n_o_set;
    logic [TIME_W-1:0]       r_o_delay, n_o_delay;
    logic                    r_o_last, n_o_last;

    logic              w_accept;
    logic              w_dl_we;
    logic [TIME_W-1:0] w_dl_rd;
    logic              w_pend_rd;
    logic              w_out_free;
    logic [TIME_W-1:0] w_op_a, w_op_b;
    logic              w_lt;
    logic [TIME_W-1:0] w_diff;
    logic [EXT_W-1:0]  w_idx_ext;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_dl_we    = w_accept && (w_req == REQ_ACTIVATE) && w_slot_ok;
    assign w_dl_rd    = r_dl_rd;
    assign w_pend_rd  = r_pend[r_idx];
    assign w_out_free = !r_ov || i_m_tready;
    assign w_idx_ext  = EXT_W'(r_idx);

    // operand select for the shared subtractor
    always_comb begin
        case (r_state)
            S_FIRE: begin
                w_op_a = r_now;
                w_op_b = w_dl_rd;
            end
            S_DECIDE: begin
                w_op_a = r_best;
                w_op_b = r_now;
            end
            default: begin
                w_op_a = w_dl_rd;
                w_op_b = r_best;
            end
        endcase
    end

    dtm_sub u_sub (
        .i_a    (w_op_a),
        .i_b    (w_op_b),
        .o_lt   (w_lt),
        .o_diff (w_diff)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_rescan   = r_rescan;
        n_slot     = r_slot;
        n_now      = r_now;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_best_vld = r_best_vld;
        n_stop     = r_stop;
        n_set      = r_set;
        n_delay    = r_delay;
        n_pend     = r_pend;
        n_ov       = r_ov;
        n_o_fired  = r_o_fired;
        n_o_fslot  = r_o_fslot;
        n_o_stop   = r_o_stop;
        n_o_set    = r_o_set;
        n_o_delay  = r_o_delay;
        n_o_last   = r_o_last;

        // result taken downstream
        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_slot     = w_slot_idx;
                    n_now      = w_now;
                    n_idx      = '0;
                    n_best_vld = 1'b0;
                    n_stop     = 1'b0;
                    n_set      = 1'b0;
                    n_delay    = '0;
                    n_rescan   = 1'b1;
                    n_state    = S_SUM;
                    case (w_req)
                        REQ_ACTIVATE: begin
                            if (w_slot_ok) begin
                                n_pend[w_slot_idx] = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        REQ_DEACTIVATE: begin
                            if (w_slot_ok && r_pend[w_slot_idx]) begin
                                n_rescan = 1'b0;
                                n_state  = S_SCAN;
                            end
                        end
                        REQ_TICK: begin
                            n_state = S_FIRE;
                        end
                        default: begin
                            n_state = S_SUM;
                        end
                    endcase
                end
            end

            // earliest pending deadline, strict compare keeps lowest slot
            S_SCAN: begin
                if (w_pend_rd && (!r_best_vld || w_lt)) begin
                    n_best     = w_dl_rd;
                    n_best_idx = r_idx;
                    n_best_vld = 1'b1;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                if (r_rescan) begin
                    // reprogram host timer, floored at zero
                    n_set   = r_best_vld;
                    n_delay = (r_best_vld && !w_lt) ? w_diff : '0;
                    n_state = S_SUM;
                end else if (r_best_idx == r_slot) begin
                    // deactivating the earliest slot: stop, then rescan
                    n_pend[r_slot] = 1'b0;
                    n_stop     = 1'b1;
                    n_rescan   = 1'b1;
                    n_best_vld = 1'b0;
                    n_idx      = '0;
                    n_state    = S_SCAN;
                end else begin
                    n_pend[r_slot] = 1'b0;
                    n_state = S_SUM;
                end
            end

            // expiry scan, one fired request per expired slot
            S_FIRE: begin
                if (w_pend_rd && !w_lt) begin
                    if (w_out_free) begin
                        n_pend[r_idx] = 1'b0;
                        n_ov      = 1'b1;
                        n_o_fired = 1'b1;
                        n_o_fslot = w_idx_ext[SLOT_FIELD_W-1:0];
                        n_o_stop  = 1'b0;
                        n_o_set   = 1'b0;
                        n_o_delay = '0;
                        n_o_last  = 1'b0;
                        n_idx     = r_idx + 1'b1;
                        if (r_idx == LAST_IDX) begin
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end

            // summary result closes the request
            S_SUM: begin
                if (w_out_free) begin
                    n_ov      = 1'b1;
                    n_o_fired = 1'b0;
                    n_o_fslot = '0;
                    n_o_stop  = r_stop;
                    n_o_set   = r_set;
                    n_o_delay = r_delay;
                    n_o_last  = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_ov    <= n_ov;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_rescan   <= n_rescan;
        r_slot     <= n_slot;
        r_now      <= n_now;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_best_vld <= n_best_vld;
        r_stop     <= n_stop;
        r_set      <= n_set;
        r_delay    <= n_delay;
        r_o_fired  <= n_o_fired;
        r_o_fslot  <= n_o_fslot;
        r_o_stop   <= n_o_stop;
        r_o_set    <= n_o_set;
        r_o_delay  <= n_o_delay;
        r_o_last   <= n_o_last;
    end

    // deadline store write, registered read at the next scan index
    // a deadline written on accept is forwarded to the first read
    always_ff @(posedge i_clk) begin
        if (w_dl_we) begin
            r_dl[w_slot_idx] <= w_deadline;
        end
        if (w_dl_we && (w_slot_idx == n_idx)) begin
            r_dl_rd <= w_deadline;
        end else begin
            r_dl_rd <= r_dl[n_idx];
        end
    end

    // result port
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {3'b000, r_o_delay, r_o_set, r_o_stop, r_o_fslot};
    assign o_m_tuser  = r_o_fired;
    assign o_m_tlast  = r_o_last;

endmodule

/* rtl/dtm_sub.sv */
// ----------------------------------------------------------------------------
// dtm_sub
// shared time subtractor: difference and less-than of two 63-bit times
// ----------------------------------------------------------------------------
module dtm_sub
    import dtm_pkg::*;
(
    input  logic [TIME_W-1:0] i_a,
    input  logic [TIME_W-1:0] i_b,
    output logic              o_lt,
    output logic [TIME_W-1:0] o_diff
);

    logic [TIME_W:0] w_full;

    // borrow out of the subtraction gives a < b
    assign w_full = {1'b0, i_a} - {1'b0, i_b};
    assign o_lt   = w_full[TIME_W];
    assign o_diff = w_full[TIME_W-1:0];

endmodule
